// ----- hdl/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// tts_pkg: shared types and constants for the text-to-integer converter
// Character token layout, unit suffix codes, configuration bundle and
// character decode helpers.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int CH_W       = 8;
  localparam int VAL_W      = 64;
  localparam int ST_W       = 2;
  localparam int DIG_W      = 5;
  localparam int SFX_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // token queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // digit value of a character that is no hex digit
  localparam logic [DIG_W-1:0] NO_DIGIT = 5'd16;

  // unit suffix codes; the shift is ten bits per step
  localparam logic [SFX_W-1:0] SFX_NONE = 3'd0;
  localparam logic [SFX_W-1:0] SFX_K    = 3'd1;
  localparam logic [SFX_W-1:0] SFX_M    = 3'd2;
  localparam logic [SFX_W-1:0] SFX_G    = 3'd3;
  localparam logic [SFX_W-1:0] SFX_T    = 3'd4;
  localparam logic [SFX_W-1:0] SFX_P    = 3'd5;

  typedef struct packed {
    logic             nul;
    logic             space;
    logic             plus;
    logic             minus;
    logic             xchr;
    logic [DIG_W-1:0] dig;
    logic [SFX_W-1:0] sfx;
  } tok_t;

  typedef struct packed {
    logic signed_mode;
    logic narrow_32;
  } cfg_t;

  function automatic logic [DIG_W-1:0] digit_of(input logic [CH_W-1:0] c);
    logic [DIG_W-1:0] d;
    d = NO_DIGIT;
    if (c >= "0" && c <= "9") begin
      d = DIG_W'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      d = DIG_W'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      d = DIG_W'(c - "A" + 8'd10);
    end
    return d;
  endfunction

  function automatic logic [SFX_W-1:0] sfx_of(input logic [CH_W-1:0] c);
    logic [SFX_W-1:0] s;
    case (c)
      "k", "K": s = SFX_K;
      "m", "M": s = SFX_M;
      "g", "G": s = SFX_G;
      "t", "T": s = SFX_T;
      "p", "P": s = SFX_P;
      default:  s = SFX_NONE;
    endcase
    return s;
  endfunction

endpackage

// ----- hdl/tts_if.sv -----
// ----------------------------------------------------------------------------
// tts_if: stream interfaces of the text-to-integer converter
// Character channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tts_ch_if import tts_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface tts_res_if import tts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic [ST_W-1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- hdl/tts_front.sv -----
// ----------------------------------------------------------------------------
// tts_front: character intake and classification
// Registers each incoming character as a decoded token (digit value,
// whitespace, sign, hex marker, unit suffix, terminator).
// ----------------------------------------------------------------------------
module tts_front import tts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  tts_ch_if.sink in_ch,
  output tok_t  tok_o,
  output logic  tok_valid_o,
  input  logic  tok_ready_i
);

  logic valid_q;
  tok_t tok_q;
  tok_t tok_d;

  assign in_ch.ready = !valid_q || tok_ready_i;

  always_comb begin
    tok_d.nul   = (in_ch.ch == 8'h00);
    tok_d.space = (in_ch.ch == 8'h20) || (in_ch.ch >= 8'h09 && in_ch.ch <= 8'h0D);
    tok_d.plus  = (in_ch.ch == "+");
    tok_d.minus = (in_ch.ch == "-");
    tok_d.xchr  = (in_ch.ch == "x") || (in_ch.ch == "X");
    tok_d.dig   = digit_of(in_ch.ch);
    tok_d.sfx   = sfx_of(in_ch.ch);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o       = tok_q;
  assign tok_valid_o = valid_q;

endmodule

// ----- hdl/tts_fifo.sv -----
// ----------------------------------------------------------------------------
// tts_fifo: token queue
// Short first-in first-out buffer between the classifier and the parser.
// ----------------------------------------------------------------------------
module tts_fifo import tts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  tok_t wr_tok_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output tok_t rd_tok_o
);

  localparam logic [QAW:0] FULL = (QAW+1)'(QDEPTH);

  tok_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q;
  logic [QAW-1:0] rd_ptr_q;
  logic [QAW:0]   cnt_q;
  logic           push;
  logic           pop;

  assign wr_ready_o = (cnt_q != FULL);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_tok_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_tok_i;
    end
  end

endmodule

// ----- hdl/tts_back.sv -----
// ----------------------------------------------------------------------------
// tts_back: parser and result pipeline
// Walks the token stream through the strtoll/strtoull base-0 grammar and,
// on a terminator, finishes the conversion in two stages into the output
// register.
// ----------------------------------------------------------------------------
module tts_back import tts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      tok_valid_i,
  output logic      tok_ready_o,
  input  tok_t      tok_i,
  tts_res_if.source out_res
);

  localparam logic [2:0] PH_WS     = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_XPFX   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_TAIL   = 3'd5;

  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_HEX = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [1:0] LEN_SAT = 2'd2;

  typedef struct packed {
    logic [2:0]       ph;
    logic             neg;
    logic [VAL_W-1:0] mag;
    logic             ovf;
    logic             conv;
    logic [1:0]       tot;
    logic [1:0]       tl;
    logic [SFX_W-1:0] sfx;
  } snap_t;

  typedef struct packed {
    logic [ST_W-1:0]  st;
    logic             shift;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] ua;
    logic [SFX_W-1:0] sfx;
  } fin_t;

  // top bits must all match the sign for a signed shift to stay in range
  function automatic logic fits_signed(input logic [VAL_W-1:0] x,
                                       input logic [SFX_W-1:0] s);
    logic r;
    case (s)
      SFX_K:   r = (&x[63:53]) || !(|x[63:53]);
      SFX_M:   r = (&x[63:43]) || !(|x[63:43]);
      SFX_G:   r = (&x[63:33]) || !(|x[63:33]);
      SFX_T:   r = (&x[63:23]) || !(|x[63:23]);
      SFX_P:   r = (&x[63:13]) || !(|x[63:13]);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic fits_unsigned(input logic [VAL_W-1:0] a,
                                         input logic [SFX_W-1:0] s);
    logic r;
    case (s)
      SFX_K:   r = !(|a[63:54]);
      SFX_M:   r = !(|a[63:44]);
      SFX_G:   r = !(|a[63:34]);
      SFX_T:   r = !(|a[63:24]);
      SFX_P:   r = !(|a[63:14]);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] shl(input logic [VAL_W-1:0] x,
                                           input logic [SFX_W-1:0] s);
    logic [VAL_W-1:0] r;
    case (s)
      SFX_K:   r = x << 10;
      SFX_M:   r = x << 20;
      SFX_G:   r = x << 30;
      SFX_T:   r = x << 40;
      SFX_P:   r = x << 50;
      default: r = x;
    endcase
    return r;
  endfunction

  // parse state
  logic [2:0]       phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [1:0]       rx_q, rx_d;
  logic [VAL_W-1:0] mag_q, mag_d;
  logic             ovf_q, ovf_d;
  logic             conv_q, conv_d;
  logic [1:0]       tot_q, tot_d;
  logic [1:0]       tl_q, tl_d;
  logic [SFX_W-1:0] sfx_q, sfx_d;

  // result pipeline
  logic             s1_v_q, s2_v_q, out_v_q;
  snap_t            s1_q;
  fin_t             s2_q, s2_d;
  logic [VAL_W-1:0] out_val_q, out_val_d;
  logic [ST_W-1:0]  out_st_q, out_st_d;
  logic             s1_ready, s2_ready, out_ready;

  logic             pop;
  logic [DIG_W-1:0] radix;
  logic [VAL_W+3:0] acc;
  logic [VAL_W-1:0] neg_mag;
  logic [1:0]       tl_eff;
  logic             over_lim;
  logic             fits;
  logic [VAL_W-1:0] v3;
  logic [ST_W-1:0]  st3;

  assign out_ready   = !out_v_q || out_res.ready;
  assign s2_ready    = !s2_v_q || out_ready;
  assign s1_ready    = !s1_v_q || s2_ready;
  // only a terminator needs room in the result pipeline
  assign tok_ready_o = !tok_i.nul || s1_ready;
  assign pop         = tok_valid_i && tok_ready_o;

  always_comb begin
    unique case (rx_q)
      RX_HEX:  radix = 5'd16;
      RX_OCT:  radix = 5'd8;
      default: radix = 5'd10;
    endcase
  end

  // magnitude * radix + digit; anything above bit 63 is an overflow
  always_comb begin
    unique case (rx_q)
      RX_HEX:  acc = {mag_q, 4'b0};
      RX_OCT:  acc = {1'b0, mag_q, 3'b0};
      default: acc = {1'b0, mag_q, 3'b0} + {3'b0, mag_q, 1'b0};
    endcase
    acc = acc + (VAL_W+4)'(tok_i.dig);
  end

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    rx_d    = rx_q;
    mag_d   = mag_q;
    ovf_d   = ovf_q;
    conv_d  = conv_q;
    tot_d   = tot_q;
    tl_d    = tl_q;
    sfx_d   = sfx_q;
    if (pop) begin
      if (tok_i.nul) begin
        phase_d = PH_WS;
        neg_d   = 1'b0;
        rx_d    = RX_DEC;
        mag_d   = '0;
        ovf_d   = 1'b0;
        conv_d  = 1'b0;
        tot_d   = '0;
        tl_d    = '0;
        sfx_d   = SFX_NONE;
      end else begin
        tot_d = (tot_q == LEN_SAT) ? tot_q : tot_q + 2'd1;
        sfx_d = tok_i.sfx;
        unique case (phase_q)
          PH_WS, PH_SIGN: begin
            if (phase_q == PH_WS && tok_i.space) begin
              phase_d = PH_WS;
            end else if (phase_q == PH_WS && (tok_i.plus || tok_i.minus)) begin
              neg_d   = tok_i.minus;
              phase_d = PH_SIGN;
            end else if (tok_i.dig == 5'd0) begin
              conv_d  = 1'b1;
              rx_d    = RX_OCT;
              mag_d   = '0;
              phase_d = PH_ZERO;
            end else if (tok_i.dig < 5'd10) begin
              conv_d  = 1'b1;
              rx_d    = RX_DEC;
              mag_d   = VAL_W'(tok_i.dig);
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_TAIL;
            end
          end
          PH_ZERO: begin
            if (tok_i.xchr) begin
              phase_d = PH_XPFX;
            end else if (tok_i.dig < 5'd8) begin
              mag_d   = VAL_W'(tok_i.dig);
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_TAIL;
              tl_d    = 2'd1;
            end
          end
          PH_XPFX: begin
            if (tok_i.dig != NO_DIGIT) begin
              rx_d    = RX_HEX;
              mag_d   = VAL_W'(tok_i.dig);
              phase_d = PH_DIGITS;
            end else begin
              phase_d = PH_TAIL;
              tl_d    = 2'd2;
            end
          end
          PH_DIGITS: begin
            if (tok_i.dig < radix) begin
              mag_d = acc[VAL_W-1:0];
              if (|acc[VAL_W+3:VAL_W]) begin
                ovf_d = 1'b1;
              end
            end else begin
              phase_d = PH_TAIL;
              tl_d    = 2'd1;
            end
          end
          PH_TAIL: begin
            tl_d = (tl_q == LEN_SAT) ? tl_q : tl_q + 2'd1;
          end
          default: begin
            phase_d = PH_WS;
          end
        endcase
      end
    end
  end

  // first finishing stage: classify the string, form the two's complement value
  always_comb begin
    neg_mag  = ~s1_q.mag + VAL_W'(1);
    tl_eff   = (s1_q.ph == PH_XPFX) ? 2'd1 : s1_q.tl;
    over_lim = cfg_i.signed_mode && s1_q.mag[VAL_W-1] &&
               (!s1_q.neg || (|s1_q.mag[VAL_W-2:0]));
    s2_d.x     = s1_q.neg ? neg_mag : s1_q.mag;
    s2_d.ua    = s1_q.mag[VAL_W-1] ? neg_mag : s1_q.mag;
    s2_d.sfx   = s1_q.sfx;
    s2_d.shift = 1'b0;
    s2_d.st    = ST_OK;
    if (s1_q.tot == 2'd0) begin
      s2_d.st = ST_OK;
    end else if (!s1_q.conv) begin
      s2_d.st = (s1_q.tot == 2'd1 && s1_q.sfx != SFX_NONE) ? ST_OK : ST_INVALID;
    end else if (s1_q.ovf || over_lim) begin
      s2_d.st = ST_RANGE;
    end else if (tl_eff == 2'd0) begin
      s2_d.st = ST_OK;
    end else if (tl_eff != 2'd1 || s1_q.sfx == SFX_NONE) begin
      s2_d.st = ST_INVALID;
    end else if (s1_q.mag != '0) begin
      s2_d.shift = 1'b1;
    end
  end

  // second finishing stage: suffix shift and 32-bit range check
  always_comb begin
    fits = cfg_i.signed_mode ? fits_signed(s2_q.x, s2_q.sfx)
                             : fits_unsigned(s2_q.ua, s2_q.sfx);
    st3  = s2_q.st;
    v3   = s2_q.x;
    if (s2_q.shift) begin
      if (!fits) begin
        st3 = ST_RANGE;
      end else begin
        v3 = shl(s2_q.x, s2_q.sfx);
      end
    end
    if (st3 == ST_OK && cfg_i.narrow_32) begin
      if (cfg_i.signed_mode) begin
        if (!((&v3[63:31]) || !(|v3[63:31]))) begin
          st3 = ST_RANGE;
        end
      end else if (v3[63] ? !((&v3[63:32]) && (|v3[31:0])) : (|v3[63:32])) begin
        st3 = ST_RANGE;
      end else begin
        v3 = {32'b0, v3[31:0]};
      end
    end
    out_st_d  = st3;
    out_val_d = (st3 == ST_OK) ? v3 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WS;
      neg_q   <= 1'b0;
      rx_q    <= RX_DEC;
      mag_q   <= '0;
      ovf_q   <= 1'b0;
      conv_q  <= 1'b0;
      tot_q   <= '0;
      tl_q    <= '0;
      sfx_q   <= SFX_NONE;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      rx_q    <= rx_d;
      mag_q   <= mag_d;
      ovf_q   <= ovf_d;
      conv_q  <= conv_d;
      tot_q   <= tot_d;
      tl_q    <= tl_d;
      sfx_q   <= sfx_d;
      if (s1_ready) begin
        s1_v_q <= pop && tok_i.nul;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (out_ready) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && tok_i.nul) begin
      s1_q.ph   <= phase_q;
      s1_q.neg  <= neg_q;
      s1_q.mag  <= mag_q;
      s1_q.ovf  <= ovf_q;
      s1_q.conv <= conv_q;
      s1_q.tot  <= tot_q;
      s1_q.tl   <= tl_q;
      s1_q.sfx  <= sfx_q;
    end
    if (s1_v_q && s2_ready) begin
      s2_q <= s2_d;
    end
    if (s2_v_q && out_ready) begin
      out_val_q <= out_val_d;
      out_st_q  <= out_st_d;
    end
  end

  assign out_res.valid  = out_v_q;
  assign out_res.value  = out_val_q;
  assign out_res.status = out_st_q;

endmodule

// ----- hdl/text_to_integer_with_suffix_unit.sv -----
// ----------------------------------------------------------------------------
// text_to_integer_with_suffix_unit: streaming text to integer converter
// Base-0 strtoll/strtoull parsing with an optional k/m/g/t/p unit suffix,
// signed or unsigned, 64-bit or 32-bit range.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+----------------------------------
//   in_ch    | in  | valid/ready      | ch[7:0], NUL ends the string
//   out_res  | out | valid/ready      | value[63:0], status[1:0]
//   cfg      | in  | cfg_we_i strobe  | cfg_idx_i, cfg_data_i
//
// One character is taken every cycle while the queue has room. A NUL passes
// the classifier register, token queue, parser snapshot and two finishing
// stages. Each digit is one multiply-by-radix-and-add in the parser, so
// characters never wait on each other. A stalled result holds the finishing
// stages; the parser drains the queue up to the next NUL, then the queue fills
// and the input stalls. Reset: leading whitespace state, signed, 64-bit.
// ----------------------------------------------------------------------------
module text_to_integer_with_suffix_unit import tts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tts_ch_if.sink                in_ch,
  tts_res_if.source             out_res,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW_32   = 1'd1;

  cfg_t cfg_q;
  tok_t front_tok;
  logic front_valid;
  logic front_ready;
  tok_t q_tok;
  logic q_valid;
  logic q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.signed_mode <= 1'b1;
      cfg_q.narrow_32   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SIGNED_MODE: cfg_q.signed_mode <= cfg_data_i[0];
        REG_NARROW_32:   cfg_q.narrow_32   <= cfg_data_i[0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  tts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .tok_o       (front_tok),
    .tok_valid_o (front_valid),
    .tok_ready_i (front_ready)
  );

  tts_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_tok_i   (front_tok),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_tok_o   (q_tok)
  );

  tts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .tok_valid_i (q_valid),
    .tok_ready_o (q_ready),
    .tok_i       (q_tok),
    .out_res     (out_res)
  );

endmodule
